@@ src/event_timeout_task_dispatcher_core_defines.svh @@
// assertion macros for the dispatcher core
`ifndef EVENT_TIMEOUT_TASK_DISPATCHER_CORE_DEFINES_SVH
`define EVENT_TIMEOUT_TASK_DISPATCHER_CORE_DEFINES_SVH

// property checked on every rising clock edge outside reset
`define ETD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`endif

@@ src/etd_pkg.sv @@
// shared types and codes of the dispatcher core
package etd_pkg;

  typedef enum logic [2:0] {
    CMD_POST  = 3'd0,
    CMD_TICK  = 3'd1,
    CMD_WAIT  = 3'd2,
    CMD_MODE  = 3'd3,
    CMD_NEXT  = 3'd4,
    CMD_START = 3'd5,
    CMD_RSVD6 = 3'd6,
    CMD_RSVD7 = 3'd7
  } cmd_t;

  localparam logic [2:0] REG_REGISTERED = 3'd0;
  localparam logic [2:0] REG_MODE_ZERO  = 3'd1;
  localparam logic [2:0] REG_MODE_THREE = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WAKE,
    ST_CHECK,
    ST_SCAN,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture input word
    logic exec;    // simple command and dispatch prologue
    logic wake;    // process one wait entry
    logic close;   // finish round close
    logic scan;    // test one task for grant
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic dispatch;   // command dispatches
    logic need_close; // open round has no runnable task
    logic last_idx;   // walker at last task
    logic stop;       // close ends without scan
    logic hit;        // scanned task granted
  } stat_t;

endpackage

@@ src/etd_ctrl.sv @@
// dispatcher controller state machine
module etd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  etd_pkg::stat_t   stat,
  output etd_pkg::ctrl_t   ctrl
);
  etd_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= etd_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      etd_pkg::ST_IDLE:  if (in_valid) state_next = etd_pkg::ST_EXEC;
      etd_pkg::ST_EXEC: begin
        priority if (!stat.dispatch) state_next = etd_pkg::ST_DONE;
        else if (stat.need_close)    state_next = etd_pkg::ST_WAKE;
        else                         state_next = etd_pkg::ST_SCAN;
      end
      etd_pkg::ST_WAKE:  if (stat.last_idx) state_next = etd_pkg::ST_CHECK;
      etd_pkg::ST_CHECK: state_next = stat.stop ? etd_pkg::ST_DONE : etd_pkg::ST_SCAN;
      etd_pkg::ST_SCAN:  if (stat.hit || stat.last_idx) state_next = etd_pkg::ST_DONE;
      etd_pkg::ST_DONE:  if (out_ready) state_next = etd_pkg::ST_IDLE;
      default:           state_next = etd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl      = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      etd_pkg::ST_IDLE:  begin in_ready = 1'b1; ctrl.load = in_valid; end
      etd_pkg::ST_EXEC:  ctrl.exec = 1'b1;
      etd_pkg::ST_WAKE:  ctrl.wake = 1'b1;
      etd_pkg::ST_CHECK: ctrl.close = 1'b1;
      etd_pkg::ST_SCAN:  ctrl.scan = 1'b1;
      etd_pkg::ST_DONE:  out_valid = 1'b1;
      default: ;
    endcase
  end
endmodule

@@ src/etd_dp.sv @@
// dispatcher datapath: wait table, sets and scan
`include "event_timeout_task_dispatcher_core_defines.svh"
module etd_dp #(
  parameter int TASK_COUNT  = 8,
  parameter int MODE_COUNT  = 4,
  parameter int EVENT_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [2:0]              cmd,
  input  logic [31:0]             event_bits,
  input  logic [31:0]             timeout_ticks,
  input  logic [1:0]              mode_select,
  input  logic                    cfg_valid,
  input  logic [2:0]              cfg_index,
  input  logic [7:0]              cfg_data,
  input  etd_pkg::ctrl_t          ctrl,
  output etd_pkg::stat_t          stat,
  output logic                    grant_valid,
  output logic [2:0]              grant_task,
  output logic                    nothing_ready,
  output logic [1:0]              active_mode
);
  localparam int TW = $clog2(TASK_COUNT);
  localparam int LW = (TASK_COUNT < 8) ? TASK_COUNT : 8;

  logic [EVENT_WIDTH-1:0] wait_masks [TASK_COUNT];
  logic [31:0]            timeouts   [TASK_COUNT];
  logic [TASK_COUNT-1:0]  registered, ready_set, round_set, runnable_set, woke;
  logic [TASK_COUNT-1:0]  mode_tab [4];
  logic [EVENT_WIDTH-1:0] pend_ev, ev_q;
  logic [31:0]            pend_ticks, tmo_q;
  logic [TW-1:0]          ptr, idx, scan_i;
  logic [TW:0]            scan_sum;
  logic                   outstanding, any_wake;
  logic [2:0]             cmd_q;
  logic [1:0]             sel_q, mode_now;
  logic                   hit_q;
  logic [TW-1:0]          hit_task;
  logic                   none_w;

  logic [TW-1:0] ptr_adv;
  logic [TASK_COUNT-1:0] rs_pro, ready_pro, run_pro;
  logic [EVENT_WIDTH-1:0] wm_sel;
  logic [31:0] to_sel;
  logic match, expire;
  logic [TASK_COUNT-1:0] cand;

  // pointer after finishing an outstanding grant
  always_comb begin
    if (!outstanding) ptr_adv = ptr;
    else if (ptr == TW'(TASK_COUNT - 1)) ptr_adv = '0;
    else ptr_adv = ptr + 1'b1;
  end

  // sets as seen by dispatch, start folds round and registered tasks back into ready set and loads mode 0
  always_comb begin
    rs_pro    = round_set;
    ready_pro = ready_set;
    run_pro   = runnable_set;
    if (cmd_q == etd_pkg::CMD_START) begin
      ready_pro = ready_set | round_set | registered;
      rs_pro    = '0;
      run_pro   = mode_tab[0];
    end
  end

  assign wm_sel = wait_masks[idx];
  assign to_sel = timeouts[idx];
  assign match  = |(wm_sel & pend_ev);
  assign expire = !match && (pend_ticks != 0) && (to_sel != 0) && (to_sel <= pend_ticks);
  assign cand   = round_set & runnable_set;
  // scan position wraps at the task count
  assign scan_sum = {1'b0, ptr} + {1'b0, idx};
  assign scan_i   = (scan_sum >= (TW+1)'(TASK_COUNT)) ?
                    TW'(scan_sum - (TW+1)'(TASK_COUNT)) : scan_sum[TW-1:0];

  always_comb begin
    stat.dispatch   = (cmd_q == etd_pkg::CMD_NEXT) || (cmd_q == etd_pkg::CMD_START);
    stat.need_close = (rs_pro & run_pro) == '0;
    stat.last_idx   = idx == TW'(TASK_COUNT - 1);
    stat.stop       = ((ready_set | woke) == '0) || (((ready_set | woke) & runnable_set) == '0);
    stat.hit        = cand[scan_i];
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_q <= cmd; ev_q <= event_bits[EVENT_WIDTH-1:0]; tmo_q <= timeout_ticks; sel_q <= mode_select;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      registered <= '0;
      for (int m = 0; m < 4; m++) mode_tab[m] <= '0;
      for (int t = 0; t < TASK_COUNT; t++) begin
        wait_masks[t] <= '0;
        timeouts[t]   <= '0;
      end
      ready_set <= '0; round_set <= '0; runnable_set <= '0; woke <= '0;
      pend_ev <= '0; pend_ticks <= '0; ptr <= '0; idx <= '0;
      outstanding <= 1'b0; mode_now <= '0;
      hit_q <= 1'b0; hit_task <= '0; any_wake <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == etd_pkg::REG_REGISTERED) registered <= cfg_data[LW-1:0];
        else if (cfg_index >= etd_pkg::REG_MODE_ZERO && cfg_index <= etd_pkg::REG_MODE_THREE)
          mode_tab[2'(cfg_index - etd_pkg::REG_MODE_ZERO)] <= cfg_data[LW-1:0];
      end
      if (ctrl.load) begin
        hit_q <= 1'b0; any_wake <= 1'b0; idx <= '0; woke <= '0;
      end
      if (ctrl.exec) begin
        unique case (etd_pkg::cmd_t'(cmd_q))
          etd_pkg::CMD_POST: pend_ev <= pend_ev | ev_q;
          etd_pkg::CMD_TICK: if (pend_ticks != '1) pend_ticks <= pend_ticks + 1'b1;
          etd_pkg::CMD_WAIT: begin
            if (ev_q == '0 && tmo_q == '0) ready_set[ptr] <= 1'b1;
            wait_masks[ptr] <= ev_q;
            timeouts[ptr]   <= tmo_q;
          end
          etd_pkg::CMD_MODE: if (32'(sel_q) < MODE_COUNT) begin
            runnable_set <= mode_tab[sel_q]; mode_now <= sel_q;
          end
          etd_pkg::CMD_NEXT, etd_pkg::CMD_START: begin
            ptr <= ptr_adv; outstanding <= 1'b0;
            runnable_set <= run_pro;
            ready_set <= stat.need_close ? (ready_pro | rs_pro) : ready_pro;
            round_set <= rs_pro;
            if (cmd_q == etd_pkg::CMD_START) mode_now <= '0;
          end
          default: ;
        endcase
      end
      if (ctrl.wake) begin
        if (match) begin
          woke[idx] <= 1'b1;
          wait_masks[idx] <= wm_sel & ~pend_ev;
          timeouts[idx] <= '0;
        end else if (pend_ticks != 0 && to_sel != 0) begin
          if (expire) begin
            wait_masks[idx] <= '0; timeouts[idx] <= '0; woke[idx] <= 1'b1;
          end else timeouts[idx] <= to_sel - pend_ticks;
        end
        idx <= stat.last_idx ? '0 : idx + 1'b1;
      end
      if (ctrl.close) begin
        pend_ev <= '0; pend_ticks <= '0;
        any_wake <= 1'b1;
        if ((ready_set | woke) == '0) begin
          round_set <= '0; ready_set <= '0;
        end else if (((ready_set | woke) & runnable_set) == '0) begin
          round_set <= '0; ready_set <= ready_set | woke;
        end else begin
          round_set <= ready_set | woke; ready_set <= '0;
        end
      end
      if (ctrl.scan) begin
        if (stat.hit) begin
          wait_masks[scan_i] <= '0;
          round_set[scan_i] <= 1'b0;
          ptr <= scan_i; outstanding <= 1'b1;
          hit_q <= 1'b1; hit_task <= scan_i;
        end
        idx <= stat.last_idx ? '0 : idx + 1'b1;
      end
    end
  end

  // result word, valid while controller is in done
  assign active_mode = mode_now;
  assign none_w = any_wake && ((ready_set | round_set) == '0) && !hit_q;
  always_comb begin
    grant_valid   = hit_q;
    grant_task    = hit_q ? 3'(hit_task) : 3'd0;
    nothing_ready = none_w;
  end

  `ETD_ASSERT(a_scan_one_hot, ctrl.scan |-> !ctrl.wake, "scan and wake overlap")
  `ETD_ASSERT(a_hit_in_round, (ctrl.scan && stat.hit) |=> !round_set[$past(scan_i)], "granted task still in round")
  `ETD_ASSERT(a_close_clears_pending, ctrl.close |=> (pend_ticks == '0), "pending ticks not cleared")
endmodule

@@ src/event_timeout_task_dispatcher_core.sv @@
// dispatcher core top level: controller plus datapath
// result word: a simple command is captured in idle, executed in exec and presented in done
// next/start closing a round: exec, wait table walk, round close check, then scan, one task per cycle
// one command at a time: a new command is taken only in idle, after the result word is accepted
// reset: synchronous active high rst clears tables, sets and counters, not the command capture
module event_timeout_task_dispatcher_core #(
  parameter int TASK_COUNT  = 8,
  parameter int MODE_COUNT  = 4,
  parameter int EVENT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  cmd,
  input  logic [31:0] event_bits,
  input  logic [31:0] timeout_ticks,
  input  logic [1:0]  mode_select,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        grant_valid,
  output logic [2:0]  grant_task,
  output logic        nothing_ready,
  output logic [1:0]  active_mode,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  etd_pkg::ctrl_t ctrl;
  etd_pkg::stat_t stat;

  // config always accepted
  assign cfg_ready = 1'b1;

  etd_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .ctrl(ctrl)
  );

  etd_dp #(.TASK_COUNT(TASK_COUNT), .MODE_COUNT(MODE_COUNT), .EVENT_WIDTH(EVENT_WIDTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .event_bits(event_bits),
    .timeout_ticks(timeout_ticks), .mode_select(mode_select),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .ctrl(ctrl), .stat(stat), .grant_valid(grant_valid), .grant_task(grant_task),
    .nothing_ready(nothing_ready), .active_mode(active_mode)
  );
endmodule

@@ dv/tb_event_timeout_task_dispatcher_core.sv @@
// testbench for the dispatcher core: directed and random commands against a scoreboard
`timescale 1ns / 1ps

module tb_event_timeout_task_dispatcher_core;

  localparam int NT = 8;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  cmd;
  logic [31:0] event_bits;
  logic [31:0] timeout_ticks;
  logic [1:0]  mode_select;
  logic        out_valid;
  logic        out_ready;
  logic        grant_valid;
  logic [2:0]  grant_task;
  logic        nothing_ready;
  logic [1:0]  active_mode;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [7:0]  cfg_data;

  event_timeout_task_dispatcher_core u_dut (.*);

  // clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one expected result word
  typedef struct packed {
    logic       gv;
    logic [2:0] gt;
    logic       none;
    logic [1:0] mode;
  } grant_word_t;

  grant_word_t grant_q[$];
  int          errors;
  int          words_sent;
  int          words_seen;
  int          grants_seen;
  bit          hold_off;      // forces a long receiver stall

  // predictor state
  logic [7:0]  p_registered;
  logic [7:0]  p_mode_tab[4];
  logic [31:0] p_wait[NT];
  logic [31:0] p_tmo[NT];
  logic [7:0]  p_ready, p_round, p_runnable;
  logic [31:0] p_pend_ev, p_pend_ticks;
  logic [2:0]  p_ptr;
  logic [1:0]  p_mode;
  logic        p_outstanding;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  // merge pending events and ticks into the wait table, return woken tasks
  function automatic logic [7:0] wake_waiters(input logic [31:0] ev, input logic [31:0] ticks);
    logic [7:0] woke;
    woke = '0;
    for (int t = 0; t < NT; t++) begin
      if ((p_wait[t] & ev) != 0) begin
        woke[t] = 1'b1;
        p_wait[t] &= ~ev;
        p_tmo[t] = '0;
      end else if (ticks != 0 && p_tmo[t] != 0) begin
        if (p_tmo[t] <= ticks) begin
          p_wait[t] = '0;
          p_tmo[t] = '0;
          woke[t] = 1'b1;
        end else begin
          p_tmo[t] -= ticks;
        end
      end
    end
    return woke;
  endfunction

  // round close and round-robin grant
  function automatic void grant_next(inout grant_word_t w);
    logic [2:0] i;
    if (p_outstanding) begin
      p_ptr++;
      p_outstanding = 1'b0;
    end
    if ((p_round & p_runnable) == 0) begin
      p_ready |= p_round;
      p_round = p_ready | wake_waiters(p_pend_ev, p_pend_ticks);
      p_pend_ev = '0;
      p_pend_ticks = '0;
      p_ready = '0;
      if (p_round == 0) begin
        w.none = 1'b1;
        return;
      end
      if ((p_round & p_runnable) == 0) begin
        p_ready |= p_round;
        p_round = '0;
        return;
      end
    end
    for (int k = 0; k < NT; k++) begin
      i = p_ptr + 3'(k);
      if (p_round[i] && p_runnable[i]) begin
        p_wait[i] = '0;
        p_round[i] = 1'b0;
        p_ptr = i;
        p_outstanding = 1'b1;
        w.gv = 1'b1;
        w.gt = i;
        return;
      end
    end
  endfunction

  function automatic grant_word_t predict_grant(input etd_pkg::cmd_t c, input logic [31:0] ev,
                                                input logic [31:0] tmo, input logic [1:0] sel);
    grant_word_t w;
    w = '0;
    case (c)
      etd_pkg::CMD_POST: p_pend_ev |= ev;
      etd_pkg::CMD_TICK: if (p_pend_ticks != 32'hFFFF_FFFF) p_pend_ticks++;
      etd_pkg::CMD_WAIT: begin
        if (ev == 0 && tmo == 0) p_ready[p_ptr] = 1'b1;
        p_wait[p_ptr] = ev;
        p_tmo[p_ptr] = tmo;
      end
      etd_pkg::CMD_MODE: begin
        p_runnable = p_mode_tab[sel];
        p_mode = sel;
      end
      etd_pkg::CMD_NEXT: grant_next(w);
      etd_pkg::CMD_START: begin
        if (p_outstanding) begin
          p_ptr++;
          p_outstanding = 1'b0;
        end
        p_ready = p_ready | p_round | p_registered;
        p_round = '0;
        p_runnable = p_mode_tab[0];
        p_mode = 2'd0;
        grant_next(w);
      end
      default: ;
    endcase
    w.mode = p_mode;
    return w;
  endfunction

  // send one command word, after a random gap unless gap is cleared; valid drops between words
  task automatic send_cmd(input etd_pkg::cmd_t c, input logic [31:0] ev = '0,
                          input logic [31:0] tmo = '0, input logic [1:0] sel = '0,
                          input bit gap = 1'b1);
    repeat (gap ? $urandom_range(0, 19) + 1 : 1) @(negedge clk);
    in_valid <= 1'b1;
    cmd <= c;
    event_bits <= ev;
    timeout_ticks <= tmo;
    mode_select <= sel;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    grant_q.push_back(predict_grant(c, ev, tmo, sel));
    words_sent++;
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // register write, only with the block idle
  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    wait (grant_q.size() == 0);
    repeat (24) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == etd_pkg::REG_REGISTERED) p_registered = val;
    else p_mode_tab[idx - etd_pkg::REG_MODE_ZERO] = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_regs(input logic [7:0] r, input logic [7:0] m0, input logic [7:0] m1,
                           input logic [7:0] m2, input logic [7:0] m3);
    write_reg(etd_pkg::REG_REGISTERED, r);
    write_reg(etd_pkg::REG_MODE_ZERO, m0);
    write_reg(etd_pkg::REG_MODE_ZERO + 3'd1, m1);
    write_reg(etd_pkg::REG_MODE_ZERO + 3'd2, m2);
    write_reg(etd_pkg::REG_MODE_THREE, m3);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 3))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h1 << $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  // receiver: per word random wait, plus a forced hold-off
  always begin : receiver
    int gap;
    out_ready <= 1'b0;
    @(negedge clk);
    while (rst || !out_valid) @(negedge clk);
    gap = $urandom_range(0, 19);
    repeat (gap) @(negedge clk);
    while (hold_off) @(negedge clk);
    out_ready <= 1'b1;
    @(posedge clk);
    @(negedge clk);
  end

  // result checker
  always @(posedge clk) begin
    grant_word_t w;
    if (!rst && out_valid && out_ready) begin
      words_seen++;
      if (grant_q.size() == 0) begin
        report("unexpected word", 0, 0);
      end else begin
        w = grant_q.pop_front();
        if (grant_valid !== w.gv) report("grant_valid", 32'(grant_valid), 32'(w.gv));
        if (grant_valid && w.gv) grants_seen++;
        if (grant_task !== w.gt) report("grant_task", 32'(grant_task), 32'(w.gt));
        if (nothing_ready !== w.none)
          report("nothing_ready", 32'(nothing_ready), 32'(w.none));
        if (active_mode !== w.mode) report("active_mode", 32'(active_mode), 32'(w.mode));
      end
    end
  end

  // edge cases: next before start, wait on task 0, reserved codes, bad fields
  task automatic test_directed();
    send_cmd(etd_pkg::CMD_NEXT);
    send_cmd(etd_pkg::CMD_WAIT, 32'h0000_0001, 32'd0);
    send_cmd(etd_pkg::CMD_RSVD6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3);
    send_cmd(etd_pkg::CMD_RSVD7);
    load_regs(8'hFF, 8'hFF, 8'h0F, 8'hF0, 8'h00);
    send_cmd(etd_pkg::CMD_START);
    send_cmd(etd_pkg::CMD_WAIT, 32'h8000_0001, 32'd3);
    send_cmd(etd_pkg::CMD_NEXT);
    send_cmd(etd_pkg::CMD_WAIT, 32'd0, 32'd0);
    send_cmd(etd_pkg::CMD_POST, 32'h8000_0000);
    send_cmd(etd_pkg::CMD_TICK);
    send_cmd(etd_pkg::CMD_MODE, 0, 0, 2'd3);
    send_cmd(etd_pkg::CMD_NEXT);
    send_cmd(etd_pkg::CMD_NEXT);
    send_cmd(etd_pkg::CMD_MODE, 0, 0, 2'd1);
    send_cmd(etd_pkg::CMD_START);
    send_cmd(etd_pkg::CMD_NEXT);
    send_cmd(etd_pkg::CMD_MODE, 0, 0, 2'd2);
    send_cmd(etd_pkg::CMD_NEXT);
    send_cmd(etd_pkg::CMD_WAIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(etd_pkg::CMD_NEXT);
  endtask

  // random traffic, mostly waits, ticks and grants
  task automatic test_random(input int count);
    etd_pkg::cmd_t c;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 19))
        0, 1, 2:     c = etd_pkg::CMD_POST;
        3, 4, 5:     c = etd_pkg::CMD_TICK;
        6, 7, 8, 9:  c = etd_pkg::CMD_WAIT;
        10:          c = etd_pkg::CMD_MODE;
        11:          c = etd_pkg::CMD_START;
        19:          c = etd_pkg::cmd_t'($urandom_range(6, 7));
        default:     c = etd_pkg::CMD_NEXT;
      endcase
      send_cmd(c, rand_word(),
               ($urandom_range(0, 1) ? 32'($urandom_range(0, 4)) : rand_word()),
               2'($urandom_range(0, 3)));
    end
  endtask

  // burst of ticks against a timed wait, then a round close
  task automatic test_tick_burst();
    send_cmd(etd_pkg::CMD_WAIT, 32'd0, 32'd30);
    for (int n = 0; n < 40; n++) send_cmd(etd_pkg::CMD_TICK);
    send_cmd(etd_pkg::CMD_NEXT);
  endtask

  // receiver stalls long while the sender keeps offering
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int n = 0; n < 12; n++) send_cmd(etd_pkg::CMD_NEXT, 0, 0, 2'd0, 1'b0);
    join
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    cmd = etd_pkg::CMD_POST;
    event_bits = '0;
    timeout_ticks = '0;
    mode_select = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    words_sent = 0;
    words_seen = 0;
    grants_seen = 0;
    hold_off = 1'b0;
    p_registered = '0;
    p_ready = '0;
    p_round = '0;
    p_runnable = '0;
    p_pend_ev = '0;
    p_pend_ticks = '0;
    p_ptr = '0;
    p_mode = '0;
    p_outstanding = 1'b0;
    for (int i = 0; i < 4; i++) p_mode_tab[i] = '0;
    for (int i = 0; i < NT; i++) begin
      p_wait[i] = '0;
      p_tmo[i] = '0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_backpressure();
    load_regs(8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()),
              8'($urandom()));
    test_random(130);
    test_random(60);
    load_regs(8'h00, 8'h00, 8'hFF, 8'hAA, 8'h55);
    test_random(100);
    load_regs(8'h81, 8'hFF, 8'($urandom()), 8'($urandom()), 8'hFF);
    test_random(60);
    test_tick_burst();

    wait (grant_q.size() == 0);
    repeat (40) @(posedge clk);
    $display("run covered %0d command words, %0d result words, %0d grants",
             words_sent, words_seen, grants_seen);
    $display("with register sweeps, random stalls and a long receiver hold-off");
    if (errors == 0) $display("PASS event_timeout_task_dispatcher_core");
    else $display("FAIL event_timeout_task_dispatcher_core");
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("FAIL event_timeout_task_dispatcher_core");
    $finish;
  end

endmodule

@@ event_timeout_task_dispatcher_core.f @@
+incdir+src
src/etd_pkg.sv
src/etd_ctrl.sv
src/etd_dp.sv
src/event_timeout_task_dispatcher_core.sv
dv/tb_event_timeout_task_dispatcher_core.sv
